FILE: sv/rsep_pkg.sv
// Shared types, constants and GF(2^8) helpers for the erasure parity encoder.
// Used by the front, queue and back modules; depends on nothing else.
package rsep_pkg;

    localparam int GF_BITS  = 8;
    localparam int GF_SIZE  = 1 << GF_BITS;
    localparam int GF_ORDER = GF_SIZE - 1;
    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1 (0x11D).
    localparam logic [GF_BITS:0] GF_POLY = 9'o435;

    typedef logic [GF_SIZE-1:0][GF_BITS-1:0] t_gf_tab;

    // One classified data byte on its way from the front to the back.
    typedef struct packed {
        logic       last;   // closes the stripe
        logic       zero;   // data byte is zero, so it has no logarithm
        logic [7:0] log_d;  // log of the data byte
        logic [7:0] log_b;  // log of the block's base, block number plus one
    } t_item;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic       REG_NATIVE   = 1'b0;
    localparam logic       REG_PARITY   = 1'b1;
    localparam logic [5:0] NATIVE_RESET = 6'd4;
    localparam logic [4:0] PARITY_RESET = 5'd2;

    function automatic t_gf_tab gen_exp();
        t_gf_tab          tab;
        logic [GF_BITS:0] x;
        tab = '0;
        x   = 9'd1;
        for (int e = 0; e < GF_ORDER; e++) begin
            tab[e] = x[7:0];
            x = {x[7:0], 1'b0};
            if (x[GF_BITS]) begin
                x = x ^ GF_POLY;
            end
        end
        tab[GF_ORDER] = tab[0];
        return tab;
    endfunction

    function automatic t_gf_tab gen_log();
        t_gf_tab tab;
        t_gf_tab ex;
        tab = '0;
        ex  = gen_exp();
        for (int e = 0; e < GF_ORDER; e++) begin
            tab[ex[e]] = 8'(e);
        end
        return tab;
    endfunction

    localparam t_gf_tab GF_EXP = gen_exp();
    localparam t_gf_tab GF_LOG = gen_log();

    // Reduce a 16-bit value modulo 255 by folding the two bytes together.
    function automatic logic [7:0] mod255(input logic [15:0] s);
        logic [8:0] s1;
        logic [8:0] s2;
        s1 = {1'b0, s[15:8]} + {1'b0, s[7:0]};
        s2 = {8'd0, s1[8]} + {1'b0, s1[7:0]};
        return (s2 == 9'd255) ? 8'd0 : s2[7:0];
    endfunction

    // Sum of two exponents that are already below 255, modulo 255.
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= 9'd255) begin
            t = t - 9'd255;
        end
        return t[7:0];
    endfunction

endpackage

FILE: sv/rsep_front.sv
// Front end: takes data bytes, tracks the block number within the stripe and
// turns each byte into a queue entry of logarithms. Depends on rsep_pkg.
module rsep_front import rsep_pkg::*; #(
    parameter int MAX_NATIVE = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clr,
    input  logic [$clog2(MAX_NATIVE+1)-1:0]   i_k_eff,
    input  logic                              i_valid,
    input  logic [7:0]                        i_data,
    output logic                              o_ready,
    input  logic                              i_q_full,
    output logic                              o_push,
    output t_item                             o_item
);

    localparam int KW = $clog2(MAX_NATIVE + 1);
    localparam int CW = (MAX_NATIVE > 1) ? $clog2(MAX_NATIVE) : 1;

    logic [CW-1:0] r_blk;
    logic [CW-1:0] n_blk;
    logic [7:0]    w_base;
    logic          w_last;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign w_base = 8'(r_blk) + 8'd1;
    assign w_last = (KW'(r_blk) + KW'(1)) == i_k_eff;

    assign o_item.last  = w_last;
    assign o_item.zero  = (i_data == 8'd0);
    assign o_item.log_d = GF_LOG[i_data];
    assign o_item.log_b = GF_LOG[w_base];

    always_comb begin
        n_blk = r_blk;
        if (o_push) begin
            n_blk = w_last ? '0 : CW'(r_blk + CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_blk <= '0;
        end else begin
            r_blk <= n_blk;
        end
    end

endmodule

FILE: sv/rsep_fifo.sv
// Short queue of classified bytes between the front and the back end.
// Depends on rsep_pkg for the entry type and depth.
module rsep_fifo import rsep_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

endmodule

FILE: sv/rsep_back.sv
// Back end: per-row exponent stage, accumulator update with table multipliers,
// parity dump shifter and output register. Depends on rsep_pkg.
module rsep_back import rsep_pkg::*; #(
    parameter int MAX_PARITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clr,
    input  logic [$clog2(MAX_PARITY+1)-1:0]  i_m_eff,
    input  logic                             i_q_valid,
    input  t_item                            i_q_item,
    output logic                             o_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [7:0]                       o_tdata,
    output logic [3:0]                       o_tuser,
    output logic                             o_tlast
);

    localparam int PN = MAX_PARITY;
    localparam int MW = $clog2(PN + 1);
    localparam int RW = (PN > 1) ? $clog2(PN) : 1;

    logic [PN-1:0][7:0] w_e;
    logic [PN-1:0][7:0] w_prod;
    logic [PN-1:0][7:0] r_e;
    logic               r_zero;
    logic               r_last;
    logic               r_v1;
    logic [PN-1:0][7:0] r_acc;
    logic [PN-1:0][7:0] r_dump;
    logic               r_busy;
    logic [RW-1:0]      r_row;
    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic [3:0]         r_orow;
    logic               r_olast;
    logic               w_row_last;
    logic               w_out_ld;
    logic               w_dump_free;
    logic               w_go;
    logic               w_dump_load;

    // Row i multiplies by (j+1)^i: exponent i*log(j+1) plus log(d), mod 255.
    for (genvar g = 0; g < PN; g++) begin : g_row
        assign w_e[g]    = add_mod255(i_q_item.log_d,
                                      mod255(16'(g) * 16'(i_q_item.log_b)));
        assign w_prod[g] = r_zero ? 8'd0 : GF_EXP[r_e[g]];
    end

    assign w_row_last  = (MW'(r_row) + MW'(1)) == i_m_eff;
    assign w_out_ld    = r_busy && (!r_ovalid || i_tready);
    assign w_dump_free = !r_busy || (w_out_ld && w_row_last);
    assign w_go        = r_v1 && (!r_last || w_dump_free);
    assign w_dump_load = w_go && r_last;
    assign o_pop       = i_q_valid && (!r_v1 || w_go);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_e    <= w_e;
            r_zero <= i_q_item.zero;
            r_last <= i_q_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_v1   <= 1'b0;
            r_acc  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (o_pop) begin
                r_v1 <= 1'b1;
            end else if (w_go) begin
                r_v1 <= 1'b0;
            end
            if (w_go) begin
                r_acc <= r_last ? '0 : (r_acc ^ w_prod);
            end
            if (w_dump_load) begin
                r_busy <= 1'b1;
            end else if (w_out_ld && w_row_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The dump bank shifts toward row zero, so the output always reads entry 0.
    always_ff @(posedge i_clk) begin
        if (w_dump_load) begin
            r_dump <= r_acc ^ w_prod;
            r_row  <= '0;
        end else if (w_out_ld) begin
            for (int i = 0; i < PN - 1; i++) begin
                r_dump[i] <= r_dump[i+1];
            end
            r_dump[PN-1] <= 8'd0;
            r_row        <= r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_obyte <= r_dump[0];
            r_orow  <= 4'(r_row);
            r_olast <= w_row_last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_obyte;
    assign o_tuser  = r_orow;
    assign o_tlast  = r_olast;

endmodule

FILE: sv/rs_erasure_parity_encoder_unit.sv
// Reed-Solomon (Vandermonde) erasure parity encoder over GF(2^8), polynomial 0x11D.
// Data bytes arrive in stripe order, one byte of each of k native blocks per
// byte position; the byte of block j is multiplied by (j+1)^i and added into
// parity row i. After the k-th byte the m parity bytes leave in row order on
// the master side, row number in tuser and tlast on the last row, and the
// accumulators start over. The block takes one data byte per cycle while the
// queue has room, and the parity dump, which drives one byte per cycle through
// a shift bank and output register while the master side is ready, overlaps
// the next stripe. When m exceeds k the dump sets the pace. The first parity
// byte follows the transfer of the k-th data byte through the queue, the
// exponent stage, the accumulator and dump load, and the output register, in
// that order. A four-entry queue between the front end and the multiplier
// stages lets either side stall.
// Writing either register restarts the stripe count and clears the accumulators
// and the dump, but entries already in the queue stay; k and m saturate to 1
// and to MAX_NATIVE and MAX_PARITY. No clearing pass follows reset.
// Depends on rsep_pkg, rsep_front, rsep_fifo and rsep_back.
module rs_erasure_parity_encoder_unit import rsep_pkg::*; #(
    parameter int MAX_NATIVE = 32,
    parameter int MAX_PARITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] parity_byte
    output logic [3:0] m_axis_tuser,   // [3:0] parity_index
    output logic       m_axis_tlast
);

    localparam int KW = $clog2(MAX_NATIVE + 1);
    localparam int MW = $clog2(MAX_PARITY + 1);

    logic [5:0]    r_native;
    logic [4:0]    r_parity;
    logic [KW-1:0] w_k_eff;
    logic [MW-1:0] w_m_eff;
    logic          w_clr;
    logic          w_push;
    logic          w_full;
    logic          w_q_valid;
    logic          w_pop;
    t_item         w_item;
    t_item         w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_native <= NATIVE_RESET;
            r_parity <= PARITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NATIVE: r_native <= i_cfg_data;
                REG_PARITY: r_parity <= i_cfg_data[4:0];
                default:    r_native <= r_native;
            endcase
        end
    end

    assign w_clr = i_cfg_we;

    always_comb begin
        if (r_native == 6'd0) begin
            w_k_eff = KW'(1);
        end else if (32'(r_native) > MAX_NATIVE) begin
            w_k_eff = KW'(MAX_NATIVE);
        end else begin
            w_k_eff = KW'(r_native);
        end
        if (r_parity == 5'd0) begin
            w_m_eff = MW'(1);
        end else if (32'(r_parity) > MAX_PARITY) begin
            w_m_eff = MW'(MAX_PARITY);
        end else begin
            w_m_eff = MW'(r_parity);
        end
    end

    rsep_front #(.MAX_NATIVE(MAX_NATIVE)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (w_clr),
        .i_k_eff  (w_k_eff),
        .i_valid  (s_axis_tvalid),
        .i_data   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_item)
    );

    rsep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    rsep_back #(.MAX_PARITY(MAX_PARITY)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_clr),
        .i_m_eff   (w_m_eff),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule

FILE: sv/rsep_checker.sv
// Port-level checks for the erasure parity encoder, attached by bind.
// Depends only on the top level's ports.
module rsep_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic [3:0] r_exp_row;

    // Rows of a stripe come out in order, starting from zero after tlast.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_row <= 4'd0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_exp_row <= m_axis_tlast ? 4'd0 : (m_axis_tuser + 4'd1);
        end
    end

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("parity output valid right after reset");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled parity transfer changed");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == r_exp_row)
        else $error("parity row out of order");

endmodule

bind rs_erasure_parity_encoder_unit rsep_checker u_rsep_checker (.*);
